>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the zero-crossing labeller.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: a named concurrent assertion over one property.
`define LSZC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The consequence must hold in the same cycle as the trigger.
`define LSZC_ASSERT_SAME(name, trig, cons, msg) \
  `LSZC_ASSERT(name, (trig) |-> (cons), msg)

// The consequence must hold in the cycle after the trigger.
`define LSZC_ASSERT_NEXT(name, trig, cons, msg) \
  `LSZC_ASSERT(name, (trig) |=> (cons), msg)

`endif

>>> sv/lszc_pkg.sv
// Shared types and constants for the level-set zero-crossing labeller.
// No dependencies; lszc_scan, lszc_label and the top-level RTL file import this package.
package lszc_pkg;

  localparam int LEVEL_W     = 24;  // input sample field
  localparam int LABEL_W     = 8;   // output label field
  localparam int COLS_REG_W  = 11;
  localparam int ROWS_REG_W  = 15;
  localparam int ROW_CNT_W   = ROWS_REG_W + 1;  // row counter runs to rows+1
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DEF_COLS       = 640;
  localparam int DEF_ROWS       = 480;
  localparam int DEF_EDGE       = 0;
  localparam int DEF_BACKGROUND = 255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_COLS       = 2'd0,
    REG_FRAME_ROWS       = 2'd1,
    REG_EDGE_VALUE       = 2'd2,
    REG_BACKGROUND_VALUE = 2'd3
  } cfg_reg_t;

  // Where the window centre of one item sits in the frame.
  typedef struct packed {
    logic emit;    // centre lies inside the frame, a label is produced
    logic border;  // centre is on the frame border
    logic last;    // centre is the frame's last pixel
  } pos_t;

endpackage

>>> sv/lszc_line_store.sv
// Line store: one synchronous memory holding the two previous rows per column.
// Registered read with enable, one write port. Uses no package items.
module lszc_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/lszc_scan.sv
// Raster position tracker: column/row counters and window-centre classification.
// Depends on lszc_pkg (pos_t, ROW_CNT_W, ROWS_REG_W).
module lszc_scan #(
  parameter int MAX_COLS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic                                 restart,
  input  logic [$clog2(MAX_COLS+1)-1:0]        eff_cols,
  input  logic [lszc_pkg::ROWS_REG_W-1:0]      eff_rows,
  output logic [$clog2(MAX_COLS)-1:0]          addr,
  output lszc_pkg::pos_t                       pos
);
  import lszc_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS + 1);

  logic [CW-1:0]        col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;

  logic [CNW-1:0]       c_ext, c_eff, c_inc, cols_m1, ccol;
  logic [ROW_CNT_W-1:0] rows_ext, rows_m1, crow;

  always_comb begin
    c_ext    = CNW'(col_r);
    c_eff    = (c_ext >= eff_cols) ? '0 : c_ext;
    cols_m1  = eff_cols - CNW'(1);
    rows_ext = ROW_CNT_W'(eff_rows);
    rows_m1  = rows_ext - ROW_CNT_W'(1);

    // Centre is one column back; at column zero it wraps to the previous row's end.
    if (c_eff != '0) begin
      ccol     = c_eff - CNW'(1);
      crow     = row_r - ROW_CNT_W'(1);
      pos.emit = (row_r >= ROW_CNT_W'(1)) && (row_r <= rows_ext);
    end else begin
      ccol     = cols_m1;
      crow     = row_r - ROW_CNT_W'(2);
      pos.emit = (row_r >= ROW_CNT_W'(2)) && (row_r <= rows_ext + ROW_CNT_W'(1));
    end
    pos.border = (crow == '0) || (crow == rows_m1) || (ccol == '0) || (ccol == cols_m1);
    pos.last   = (crow == rows_m1) && (ccol == cols_m1);
    addr       = c_eff[CW-1:0];

    c_inc = c_eff + CNW'(1);
    if (c_inc >= eff_cols) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_CNT_W'(1);
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = row_r;
    end
    if (pos.emit && pos.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> sv/lszc_label.sv
// 3x3 window registers, zero-crossing test and the output register.
// Depends on lszc_pkg (pos_t, LABEL_W).
module lszc_label #(
  parameter int VALUE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         col_adv,
  output logic                         col_ready,
  input  logic [VALUE_BITS-1:0]        col_up,
  input  logic [VALUE_BITS-1:0]        col_mid,
  input  logic [VALUE_BITS-1:0]        col_new,
  input  lszc_pkg::pos_t               col_pos,
  input  logic [lszc_pkg::LABEL_W-1:0] edge_value,
  input  logic [lszc_pkg::LABEL_W-1:0] background_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lszc_pkg::LABEL_W-1:0] out_label,
  output logic                         out_last
);
  import lszc_pkg::*;

  localparam int VB = VALUE_BITS;

  logic [VB-1:0]      win_r [3][3];
  logic               s2_valid_r;
  pos_t               s2_pos_r;
  logic               out_valid_r;
  logic [LABEL_W-1:0] out_label_r;
  logic               out_last_r;

  logic               out_free, s2_adv, out_load, hit;
  logic [VB-2:0]      mag_p;
  logic               p_zero, p_pos;

  // Magnitude saturates for the most negative value.
  function automatic logic [VB-2:0] mag(input logic [VB-1:0] v);
    logic [VB-1:0] neg;
    neg = ~v + VB'(1);
    if (!v[VB-1]) begin
      return v[VB-2:0];
    end else if (v[VB-2:0] == '0) begin
      return '1;
    end else begin
      return neg[VB-2:0];
    end
  endfunction

  always_comb begin
    mag_p  = mag(win_r[1][1]);
    p_zero = (win_r[1][1] == '0);
    p_pos  = !win_r[1][1][VB-1] && !p_zero;
    hit    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          if (p_zero) begin
            if (win_r[i][j] != '0) hit = 1'b1;
          end else if ((mag_p < mag(win_r[i][j])) &&
                       (p_pos != (!win_r[i][j][VB-1] && (win_r[i][j] != '0)))) begin
            hit = 1'b1;
          end
        end
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign s2_adv    = s2_valid_r && (!s2_pos_r.emit || out_free);
  assign out_load  = s2_valid_r && s2_pos_r.emit && out_free;
  assign col_ready = !s2_valid_r || s2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (col_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= col_up;
      win_r[1][2] <= col_mid;
      win_r[2][2] <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (col_adv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (col_adv) begin
      s2_pos_r <= col_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_label_r <= (!s2_pos_r.border && hit) ? edge_value : background_value;
      out_last_r  <= s2_pos_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_label = out_label_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/level_set_zero_crossing_edges_top.sv
// Channel | dir | beat contents
// in_*    | in  | tdata[23:0] level_value; tuser flush
// out_*   | out | tdata[7:0] edge_label; tlast frame_end
// cfg_*   | in  | cfg_index register index, cfg_data write data
//
// One item per cycle sustained while out_tready is high; after its beat is taken a label
// passes line-store read, window shift and crossing test into the output register.
// The line store is one memory read and written once per item; a read that
// hits the entry written in the same cycle is served from a forward register.
// Reset clears counters, window and valids; the line store is not cleared.
// out_tready low holds the output register and stalls the stages behind it.
// Depends on lszc_pkg, lszc_scan, lszc_line_store, lszc_label, assert_macros.svh.
`include "assert_macros.svh"

module level_set_zero_crossing_edges_top #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lszc_pkg::LEVEL_W-1:0]     in_tdata,   // [23:0] level_value
  input  logic                             in_tuser,   // [0] flush
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lszc_pkg::LABEL_W-1:0]     out_tdata,  // [7:0] edge_label
  output logic                             out_tlast,  // frame_end
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lszc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lszc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lszc_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int VB  = VALUE_BITS;
  localparam int RST_COLS = (DEF_COLS > MAX_COLS) ? MAX_COLS : DEF_COLS;

  // Configuration
  logic [CNW-1:0]        eff_cols_r;
  logic [ROWS_REG_W-1:0] eff_rows_r;
  logic [LABEL_W-1:0]    edge_value_r, background_value_r;
  logic [COLS_REG_W-1:0] cols_raw;
  logic [ROWS_REG_W-1:0] rows_raw;
  logic [CNW-1:0]        cols_clamp;
  logic                  cfg_wr, size_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cols_raw  = cfg_data[COLS_REG_W-1:0];
  assign rows_raw  = cfg_data[ROWS_REG_W-1:0];
  assign size_wr   = cfg_wr && ((cfg_reg_t'(cfg_index) == REG_FRAME_COLS) ||
                                (cfg_reg_t'(cfg_index) == REG_FRAME_ROWS));

  always_comb begin
    if (cols_raw == '0) begin
      cols_clamp = CNW'(1);
    end else if (int'(cols_raw) > MAX_COLS) begin
      cols_clamp = CNW'(MAX_COLS);
    end else begin
      cols_clamp = CNW'(cols_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_cols_r         <= CNW'(RST_COLS);
      eff_rows_r         <= ROWS_REG_W'(DEF_ROWS);
      edge_value_r       <= LABEL_W'(DEF_EDGE);
      background_value_r <= LABEL_W'(DEF_BACKGROUND);
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_COLS:       eff_cols_r <= cols_clamp;
        REG_FRAME_ROWS:       eff_rows_r <= (rows_raw == '0) ? ROWS_REG_W'(1) : rows_raw;
        REG_EDGE_VALUE:       edge_value_r <= cfg_data[LABEL_W-1:0];
        REG_BACKGROUND_VALUE: background_value_r <= cfg_data[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: accept, position, line-store read
  logic          in_accept;
  logic [CW-1:0] scan_addr;
  pos_t          scan_pos;
  logic [VB-1:0] in_x;

  assign in_accept = in_tvalid && in_tready;
  assign in_x      = in_tuser ? '0 : VB'(in_tdata);

  lszc_scan #(.MAX_COLS(MAX_COLS)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_accept),
    .restart  (size_wr),
    .eff_cols (eff_cols_r),
    .eff_rows (eff_rows_r),
    .addr     (scan_addr),
    .pos      (scan_pos)
  );

  // Stage B: read data back, write the shifted entry, feed the window
  logic            s1_valid_r;
  logic [VB-1:0]   s1_x_r;
  logic [CW-1:0]   s1_addr_r;
  pos_t            s1_pos_r;
  logic            fwd_r;
  logic [2*VB-1:0] fwd_data_r;
  logic [2*VB-1:0] rd_data, entry, wr_data;
  logic            s1_adv, col_ready;

  // Entry layout: upper row in the high half, middle row in the low half.
  assign entry   = fwd_r ? fwd_data_r : rd_data;
  assign wr_data = {entry[VB-1:0], s1_x_r};
  assign s1_adv  = s1_valid_r && col_ready;

  assign in_tready = !s1_valid_r || s1_adv;

  lszc_line_store #(.DEPTH(MAX_COLS), .AW(CW), .DW(2*VB)) u_line_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (scan_addr),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Read and write of one entry at the same edge: the read returns stale data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r     <= in_x;
      s1_addr_r  <= scan_addr;
      s1_pos_r   <= scan_pos;
      fwd_r      <= s1_adv && (s1_addr_r == scan_addr);
      fwd_data_r <= wr_data;
    end
  end

  // Stage C and output register
  lszc_label #(.VALUE_BITS(VB)) u_label (
    .clk              (clk),
    .rst_n            (rst_n),
    .col_adv          (s1_adv),
    .col_ready        (col_ready),
    .col_up           (entry[2*VB-1:VB]),
    .col_mid          (entry[VB-1:0]),
    .col_new          (s1_x_r),
    .col_pos          (s1_pos_r),
    .edge_value       (edge_value_r),
    .background_value (background_value_r),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_label        (out_tdata),
    .out_last         (out_tlast)
  );

  `LSZC_ASSERT_SAME(a_no_bubble, out_tready, in_tready, "input stalled while output drains")
  `LSZC_ASSERT_NEXT(a_fwd_empty, in_accept && !s1_valid_r, !fwd_r, "forward without write")
  `LSZC_ASSERT_NEXT(a_flush_zero, in_accept && in_tuser, s1_x_r == '0, "flush sample not zero")

endmodule

>>> tb/level_set_zero_crossing_edges_top_tb.sv
// Self-checking bench for level_set_zero_crossing_edges_top: predicts every edge label
// from the accepted sample beats and checks it against the label stream in order.
// Depends on lszc_pkg and the RTL of the labeller; nothing else.
module level_set_zero_crossing_edges_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lszc_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic               last;
    logic [LABEL_W-1:0] label;
  } label_beat_t;

  // Window predictor plus the queue of labels it still owes.
  class crossing_labeller;
    localparam int LINE_DEPTH = 1024;
    localparam int MAG_TOP    = (1 << (LEVEL_W - 1)) - 1;

    label_beat_t           pending_labels[$];
    int                    mismatches;
    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;
    logic [LABEL_W-1:0]    edge_lab;
    logic [LABEL_W-1:0]    bg_lab;
    int                    upper_line[LINE_DEPTH];
    int                    middle_line[LINE_DEPTH];
    int                    win[3][3];
    int                    col_cnt;
    int                    row_cnt;

    function new();
      cols_reg   = COLS_REG_W'(DEF_COLS);
      rows_reg   = ROWS_REG_W'(DEF_ROWS);
      edge_lab   = LABEL_W'(DEF_EDGE);
      bg_lab     = LABEL_W'(DEF_BACKGROUND);
      mismatches = 0;
      col_cnt    = 0;
      row_cnt    = 0;
    endfunction

    function int cols_in_use();
      if (cols_reg == 0) return 1;
      if (cols_reg > LINE_DEPTH) return LINE_DEPTH;
      return int'(cols_reg);
    endfunction

    function int rows_in_use();
      return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_COLS: begin
          cols_reg = data[COLS_REG_W-1:0];
          col_cnt  = 0;
          row_cnt  = 0;
        end
        REG_FRAME_ROWS: begin
          rows_reg = data[ROWS_REG_W-1:0];
          col_cnt  = 0;
          row_cnt  = 0;
        end
        REG_EDGE_VALUE:       edge_lab = data[LABEL_W-1:0];
        REG_BACKGROUND_VALUE: bg_lab   = data[LABEL_W-1:0];
        default: ;
      endcase
    endfunction

    function int magnitude(int v);
      int a;
      a = (v < 0) ? -v : v;
      return (a > MAG_TOP) ? MAG_TOP : a;
    endfunction

    function bit crosses();
      int p;
      int mp;
      int n;
      bit hit;
      p   = win[1][1];
      mp  = magnitude(p);
      hit = 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          n = win[i][j];
          if (!(i == 1 && j == 1)) begin
            if (p == 0) begin
              if (n != 0) hit = 1'b1;
            end else if (mp < magnitude(n) && ((p > 0) != (n > 0))) begin
              hit = 1'b1;
            end
          end
        end
      end
      return hit;
    endfunction

    function void take_sample(logic [LEVEL_W-1:0] raw, logic flush);
      int cols;
      int rows;
      int c;
      int r;
      int x;
      int up;
      int mid;
      int crow;
      int ccol;
      bit border;
      label_beat_t beat;
      cols = cols_in_use();
      rows = rows_in_use();
      c    = col_cnt;
      r    = row_cnt;
      if (flush) x = 0;
      else x = int'($signed(raw));
      if (c >= cols) c = 0;
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = x;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = x;
      // centre sits one row and one column behind the incoming sample
      if (c >= 1) begin
        crow = r - 1;
        ccol = c - 1;
      end else begin
        crow = r - 2;
        ccol = cols - 1;
      end
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
      end
      col_cnt = c;
      row_cnt = r;
      if (crow < 0 || crow >= rows) return;
      border = (crow == 0) || (crow == rows - 1) || (ccol == 0) || (ccol == cols - 1);
      beat.last  = (crow == rows - 1) && (ccol == cols - 1);
      beat.label = (!border && crosses()) ? edge_lab : bg_lab;
      pending_labels.push_back(beat);
      if (beat.last) begin
        col_cnt = 0;
        row_cnt = 0;
      end
    endfunction

    function void match_label(logic [LABEL_W-1:0] label, logic last);
      label_beat_t want;
      if (pending_labels.size() == 0) begin
        $display("%0t: unexpected label beat %0h last %0b", $time, label, last);
        mismatches++;
        return;
      end
      want = pending_labels.pop_front();
      if (want.label !== label) begin
        $display("%0t: edge_label expected %0h actual %0h", $time, want.label, label);
        mismatches++;
      end
      if (want.last !== last) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [LEVEL_W-1:0]     in_tdata;   // [23:0] level_value
  logic                   in_tuser;   // [0] flush
  logic                   out_tvalid;
  logic                   out_tready;
  logic [LABEL_W-1:0]     out_tdata;  // [7:0] edge_label
  logic                   out_tlast;  // frame_end
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  crossing_labeller board;
  int               sender_idle;
  int               recv_idle;
  int               sent_items;
  bit               stall_request;
  logic [LEVEL_W:0] directed_beats[0:25];  // bit 24 = flush

  level_set_zero_crossing_edges_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.apply_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (out_tvalid && out_tready) board.match_label(out_tdata, out_tlast);
      if (in_tvalid && in_tready) board.take_sample(in_tdata, in_tuser);
    end
  end

  // Label sink: random backpressure, or one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #5ms;
    $display("level_set_zero_crossing_edges_top regression: fail");
    $finish;
  end

  function automatic logic [LEVEL_W-1:0] level_sample();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3, 4:    return LEVEL_W'(int'($urandom_range(14)) - 7);
      5: begin
        case ($urandom_range(4))
          0:       return 24'h800000;
          1:       return 24'h7FFFFF;
          2:       return 24'h800001;
          3:       return 24'hFFFFFF;
          default: return 24'h000001;
        endcase
      end
      6, 7:    return LEVEL_W'(int'($urandom_range(2000)) - 1000);
      default: return LEVEL_W'($urandom());
    endcase
  endfunction

  // Entered and left at a falling edge.
  task automatic send_sample(input logic [LEVEL_W-1:0] value, input logic flush);
    while ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= flush;
    do @(posedge clk); while (!in_tready);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int pixels, input int tail, input int stall_at);
    for (int k = 0; k < pixels + tail; k++) begin
      if (k == stall_at) stall_request = 1'b1;
      if (k < pixels) send_sample(level_sample(), $urandom_range(19) == 0);
      else if ($urandom_range(6) == 0) send_sample(level_sample(), 1'b0);
      else send_sample(LEVEL_W'($urandom()), 1'b1);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_frame(input int cols, input int rows, input int edge_lab,
                               input int bg_lab, input bit sizes);
    cfg_write(REG_EDGE_VALUE, CFG_DATA_W'(edge_lab));
    cfg_write(REG_BACKGROUND_VALUE, CFG_DATA_W'(bg_lab));
    if (sizes) begin
      cfg_write(REG_FRAME_COLS, CFG_DATA_W'(cols));
      cfg_write(REG_FRAME_ROWS, CFG_DATA_W'(rows));
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering beats until every label is back, then cover the pipeline depth.
  task automatic wait_drained();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (board.pending_labels.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (board.pending_labels.size() != 0) begin
      $display("%0t: %0d expected labels never arrived", $time,
               board.pending_labels.size());
      board.mismatches++;
      board.pending_labels.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input int cols, input int rows, input int edge_lab,
                           input int bg_lab, input bit sizes, input int frames,
                           input int cut_limit, input int stall_at);
    int span_c;
    int span_r;
    int cut;
    program_frame(cols, rows, edge_lab, bg_lab, sizes);
    span_c = board.cols_in_use();
    span_r = board.rows_in_use();
    repeat (frames) send_frame(span_c * span_r, span_c + 1, stall_at);
    if (cut_limit > 0) begin
      // frame cut short before its tail
      cut = (cut_limit < span_c * span_r) ? cut_limit : span_c * span_r;
      send_frame($urandom_range(1, cut), 0, -1);
    end
    wait_drained();
  endtask

  initial begin
    int done;
    int cols;
    int rows;
    int edge_lab;
    int bg_lab;
    int random_start;
    board         = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_FRAME_COLS;
    cfg_data      = '0;
    stall_request = 1'b0;
    sent_items    = 0;
    sender_idle   = 33;
    recv_idle     = 58;
    // 3x3 frames: flushed zero centre among nonzero neighbours, then a
    // most-negative centre whose saturated magnitude ties the largest positive
    directed_beats = '{
      25'h07FFFFF, 25'h0800000, 25'h0000000,
      25'h0000001, 25'h1FFFFFF, 25'h0FFFFFF,
      25'h0000000, 25'h0000000, 25'h0800001,
      25'h1000000, 25'h1AAAAAA, 25'h1555555, 25'h1000000,
      25'h0000000, 25'h0000000, 25'h0000000,
      25'h07FFFFF, 25'h0800000, 25'h0000005,
      25'h0000000, 25'h0FFFFFF, 25'h0000000,
      25'h1123456, 25'h1000000, 25'h1FEDCBA, 25'h1000000
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // upper data bits beyond the register widths are dropped
    program_frame(32'hF803, 32'h8003, 8'hA5, 8'h5A, 1'b1);
    for (int k = 0; k < 26; k++) begin
      send_sample(directed_beats[k][LEVEL_W-1:0], directed_beats[k][LEVEL_W]);
    end
    wait_drained();

    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      done        = sent_items - random_start;
      sender_idle = (done < RANDOM_ITEMS / 3) ? 33 : (done < 2 * RANDOM_ITEMS / 3) ? 58 : 0;
      recv_idle   = (done < RANDOM_ITEMS / 3) ? 58 : (done < 2 * RANDOM_ITEMS / 3) ? 33 : 0;
      case ($urandom_range(9))
        0:       cols = $urandom_range(2);
        1:       cols = $urandom_range(9, 20);
        default: cols = $urandom_range(3, 8);
      endcase
      case ($urandom_range(7))
        0:       rows = $urandom_range(2);
        default: rows = $urandom_range(3, 7);
      endcase
      case ($urandom_range(9))
        0: begin
          edge_lab = 0;
          bg_lab   = 255;
        end
        1: begin
          edge_lab = 255;
          bg_lab   = 0;
        end
        default: begin
          edge_lab = $urandom_range(255);
          bg_lab   = $urandom_range(255);
        end
      endcase
      run_phase(cols, rows, edge_lab, bg_lab, $urandom_range(3) != 0,
                $urandom_range(1, 3), ($urandom_range(2) == 0) ? 1000 : 0, -1);
    end

    // no idling; the sink holds off mid-frame, then a one-column frame
    // and a tall frame cut short
    sender_idle = 0;
    recv_idle   = 0;
    run_phase(16, 6, 255, 0, 1'b1, 1, 0, 40);
    run_phase(1, 40, 8'h3C, 8'hC3, 1'b1, 1, 0, -1);
    run_phase(4, 32767, 8'h01, 8'h02, 1'b1, 0, 40, -1);

    if (board.mismatches == 0) begin
      $display("level_set_zero_crossing_edges_top regression: pass");
    end else begin
      $display("level_set_zero_crossing_edges_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/lszc_pkg.sv
sv/lszc_line_store.sv
sv/lszc_scan.sv
sv/lszc_label.sv
sv/level_set_zero_crossing_edges_top.sv
tb/level_set_zero_crossing_edges_top_tb.sv
